// ===== rtl/core/tes_pkg.sv =====
`timescale 1ns / 1ps

package tes_pkg;

    // input word: one record of a set
    typedef struct packed {
        logic signed [31:0] key;
        logic        [7:0]  tag;
        logic               last;
    } t_in_word;

    // output word: one record of the sorted run
    typedef struct packed {
        logic        [7:0]  out_tag;
        logic signed [31:0] out_key;
        logic               out_last;
        logic               dropped;
    } t_out_word;

    // stored record
    typedef struct packed {
        logic signed [31:0] key;
        logic        [7:0]  tag;
    } t_rec;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MODE   = 4'd1;

    // memory read address select
    localparam logic [1:0] RD_SEL_I  = 2'd0;  // position i
    localparam logic [1:0] RD_SEL_I1 = 2'd1;  // position i + 1
    localparam logic [1:0] RD_SEL_J1 = 2'd2;  // position j + 1
    localparam logic [1:0] RD_SEL_K  = 2'd3;  // emit position k

    typedef struct packed {
        logic       in_ready;  // load phase, input side open
        logic       ld_cur;    // latch entry i as the running holder
        logic       cmp;       // compare holder with entry j, swap if out of order
        logic       wr_cur;    // write holder back to entry i, advance i
        logic       emit;      // move entry k into the output register
        logic       clr_set;   // end of set: clear count, previous key, flag, i and k
        logic [1:0] rd_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_last_fire;  // last word accepted this cycle
        logic single;        // only one record stored
        logic j_end;         // j is the final position
        logic i_end;         // i is the final outer position
        logic k_end;         // k is the final emit position
        logic out_free;      // output register can take a word
    } t_dp_stat;

endpackage

// ===== rtl/core/tagged_exchange_sort.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Word
// in       input      i_in_valid / o_in_stall   t_in_word  (key, tag, last)
// out      output     o_out_valid / i_out_stall t_out_word (out_tag, out_key, out_last, dropped)
// cfg      input      i_cfg_valid / o_cfg_ready index i_cfg_index, data i_cfg_data[0]
//
// Load takes one word per cycle. After the last word, the sort reads i, loads
// the holder, compare-swaps over j and writes i back for each outer position,
// paced by the single read and write port of the record memory and one
// compare-swap per cycle. Emit: memory read, then output register.
// Reset is synchronous, active low; it clears the set state and registers.
// The input stalls from the last word of a set until its final result is
// loaded into the output register; an output stall holds that register.

module tagged_exchange_sort
    import tes_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_word,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_word             o_out_word,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // register writes never wait
    assign o_cfg_ready = 1'b1;

    // input side open only during the load phase
    assign o_in_stall = !w_cmd.in_ready;

    tes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    tes_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // at most one datapath operation per cycle
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.in_ready, w_cmd.ld_cur, w_cmd.cmp, w_cmd.wr_cur, w_cmd.emit}))
        else $error("overlapping datapath commands");

    // a result never overwrites one still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("emit into a stalled output register");

    // the last word of a set closes the input side
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.last) |=> o_in_stall)
        else $error("input open after last word");

    // end of set only together with the final emit
    a_clr_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_set |-> (w_cmd.emit && w_stat.k_end))
        else $error("set cleared before final result");

endmodule

// ===== rtl/core/tes_ctrl.sv =====
`timescale 1ns / 1ps

module tes_ctrl
    import tes_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RDI  = 3'd2;
    localparam logic [2:0] S_LDI  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_WRI  = 3'd5;
    localparam logic [2:0] S_ERD  = 3'd6;
    localparam logic [2:0] S_EOUT = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_last_fire) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.rd_sel = RD_SEL_I;
                n_state = i_stat.single ? S_ERD : S_RDI;
            end
            S_RDI: begin
                o_cmd.rd_sel = RD_SEL_I;
                n_state = S_LDI;
            end
            S_LDI: begin
                o_cmd.ld_cur = 1'b1;
                o_cmd.rd_sel = RD_SEL_I1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp    = 1'b1;
                o_cmd.rd_sel = RD_SEL_J1;
                if (i_stat.j_end) begin
                    n_state = S_WRI;
                end
            end
            S_WRI: begin
                o_cmd.wr_cur = 1'b1;
                o_cmd.rd_sel = RD_SEL_I;
                n_state = i_stat.i_end ? S_ERD : S_RDI;
            end
            S_ERD: begin
                o_cmd.rd_sel = RD_SEL_K;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                o_cmd.rd_sel = RD_SEL_K;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.k_end) begin
                        o_cmd.clr_set = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ===== rtl/core/tes_dp.sv =====
`timescale 1ns / 1ps

module tes_dp
    import tes_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_word,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_word             o_out_word
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CW1 = CW + 1;

    // record memory, one write and one registered read per cycle
    t_rec r_mem [DEPTH];
    t_rec r_rd;

    logic          r_descending;
    logic          r_gap_mode;
    logic [CW-1:0] r_count;
    logic [31:0]   r_prev;
    logic          r_ovf;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_k;
    t_rec          r_cur;
    logic          r_out_valid;
    t_out_word     r_out;

    logic          w_accept;
    logic          w_full;
    logic          w_swap;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_rec          w_wdata;
    logic [AW-1:0] w_raddr;
    logic [32:0]   w_diff;
    logic [31:0]   w_gap;
    logic [31:0]   w_stored;

    assign w_accept = i_cmd.in_ready && i_in_valid;
    assign w_full   = (r_count == CW'(DEPTH));

    // key minus previous key, clamped to 32 bits
    assign w_diff = {i_in_word.key[31], i_in_word.key} - {r_prev[31], r_prev};
    always_comb begin
        if (w_diff[32] != w_diff[31]) begin
            w_gap = w_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_gap = w_diff[31:0];
        end
    end
    assign w_stored = (r_gap_mode && (r_count != '0)) ? w_gap : i_in_word.key;

    assign w_swap = r_descending ? (r_cur.key < r_rd.key) : (r_cur.key > r_rd.key);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i;
        w_wdata = r_cur;
        if (w_accept && !w_full) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
            w_wdata = '{key: w_stored, tag: i_in_word.tag};
        end else if (i_cmd.cmp && w_swap) begin
            w_we    = 1'b1;
            w_waddr = r_j;
        end else if (i_cmd.wr_cur) begin
            w_we    = 1'b1;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_SEL_I:  w_raddr = r_i;
            RD_SEL_I1: w_raddr = r_i + AW'(1);
            RD_SEL_J1: w_raddr = r_j + AW'(1);
            RD_SEL_K:  w_raddr = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
            r_gap_mode   <= 1'b0;
        end else if (i_cfg_wr) begin
            if (i_cfg_index == CFG_DESCENDING) begin
                r_descending <= i_cfg_data[0];
            end
            if (i_cfg_index == CFG_GAP_MODE) begin
                r_gap_mode <= i_cfg_data[0];
            end
        end
    end

    // set state and sort counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            if (w_accept) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                    r_prev  <= i_in_word.key;
                end
            end
            if (i_cmd.ld_cur) begin
                r_j <= r_i + AW'(1);
            end
            if (i_cmd.cmp) begin
                r_j <= r_j + AW'(1);
            end
            if (i_cmd.wr_cur) begin
                r_i <= r_i + AW'(1);
            end
            if (i_cmd.emit) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.clr_set) begin
                r_count <= '0;
                r_prev  <= '0;
                r_ovf   <= 1'b0;
                r_i     <= '0;
                r_k     <= '0;
            end
        end
    end

    // running holder of position i
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_cur || (i_cmd.cmp && w_swap)) begin
            r_cur <= r_rd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.out_tag  <= r_rd.tag;
            r_out.out_key  <= r_rd.key;
            r_out.out_last <= o_stat.k_end;
            r_out.dropped  <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign o_stat.in_last_fire = w_accept && i_in_word.last;
    assign o_stat.single       = (r_count == CW'(1));
    assign o_stat.j_end        = (CW1'(r_j) + CW1'(1) == CW1'(r_count));
    assign o_stat.i_end        = (CW1'(r_i) + CW1'(2) == CW1'(r_count));
    assign o_stat.k_end        = (CW1'(r_k) + CW1'(1) == CW1'(r_count));
    assign o_stat.out_free     = !r_out_valid || !i_out_stall;

endmodule

// ===== test/tagged_exchange_sort_chk.sv =====
`timescale 1ns / 1ps

// Watches the in, out and cfg channels, keeps its own copy of the set state
// and queues the sorted run that each last word should produce.
module tagged_exchange_sort_chk
    import tes_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_word,
    input  logic                  i_in_stall,
    input  logic                  i_out_valid,
    input  t_out_word             i_out_word,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_cfg_ready,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic               descending;
    logic               gap_mode;
    logic signed [31:0] rec_key [DEPTH];
    logic        [7:0]  rec_tag [DEPTH];
    int                 rec_count;
    logic signed [31:0] prev_key;
    logic               overflow_seen;
    t_out_word          sorted_q[$];
    int                 fails = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        fails++;
    endtask

    function automatic logic signed [31:0] clamped_gap(input logic signed [31:0] cur,
                                                       input logic signed [31:0] prv);
        longint d;
        d = longint'(cur) - longint'(prv);
        if (d > longint'(32'sh7fffffff))
            return 32'sh7fffffff;
        if (d < longint'(32'sh80000000))
            return 32'sh80000000;
        return d[31:0];
    endfunction

    // exchange sort of the stored set, then one expected word per record
    task automatic queue_sorted_run();
        logic signed [31:0] k [DEPTH];
        logic        [7:0]  t [DEPTH];
        logic signed [31:0] kt;
        logic        [7:0]  tt;
        logic               swap;
        t_out_word          w;
        for (int i = 0; i < rec_count; i++) begin
            k[i] = rec_key[i];
            t[i] = rec_tag[i];
        end
        for (int i = 0; i < rec_count; i++) begin
            for (int j = i + 1; j < rec_count; j++) begin
                swap = descending ? (k[i] < k[j]) : (k[i] > k[j]);
                if (swap) begin
                    kt = k[i]; tt = t[i];
                    k[i] = k[j]; t[i] = t[j];
                    k[j] = kt; t[j] = tt;
                end
            end
        end
        for (int i = 0; i < rec_count; i++) begin
            w.out_tag  = t[i];
            w.out_key  = k[i];
            w.out_last = (i == rec_count - 1);
            w.dropped  = overflow_seen;
            sorted_q.push_back(w);
        end
        rec_count     = 0;
        prev_key      = '0;
        overflow_seen = 1'b0;
    endtask

    task automatic take_word(input t_in_word w);
        if (rec_count < DEPTH) begin
            rec_key[rec_count] = (gap_mode && rec_count != 0) ?
                                 clamped_gap(w.key, prev_key) : w.key;
            rec_tag[rec_count] = w.tag;
            prev_key           = w.key;
            rec_count++;
        end else begin
            overflow_seen = 1'b1;
        end
        if (w.last)
            queue_sorted_run();
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            descending    = 1'b0;
            gap_mode      = 1'b0;
            rec_count     = 0;
            prev_key      = '0;
            overflow_seen = 1'b0;
            sorted_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sorted_q.size() == 0) begin
                    report_mismatch("output word with none expected", i_out_word.out_key, '0);
                end else begin
                    want = sorted_q.pop_front();
                    if (i_out_word.out_tag !== want.out_tag)
                        report_mismatch("out_tag", i_out_word.out_tag, want.out_tag);
                    if (i_out_word.out_key !== want.out_key)
                        report_mismatch("out_key", i_out_word.out_key, want.out_key);
                    if (i_out_word.out_last !== want.out_last)
                        report_mismatch("out_last", i_out_word.out_last, want.out_last);
                    if (i_out_word.dropped !== want.dropped)
                        report_mismatch("dropped", i_out_word.dropped, want.dropped);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DESCENDING: descending = i_cfg_data[0];
                    CFG_GAP_MODE:   gap_mode   = i_cfg_data[0];
                    default:        ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                take_word(i_in_word);
        end
        o_pending    = sorted_q.size();
        o_fail_count = fails;
    end

endmodule

// ===== test/tagged_exchange_sort_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict. A directed part covers field extremes, equal keys,
// a single-record set, overflow (last word arriving while full) and gap
// saturation both ways; then eight random phases walk every register
// setting under four idling mixes. The checker does all the predicting.
module tagged_exchange_sort_tb;
    import tes_pkg::*;

    localparam int DEPTH         = 8;
    localparam int PHASES        = 8;
    localparam int RANDOM_WORDS  = 340;
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 30;    // idle gap before the next register write
    localparam int QUIET_LIMIT   = 4000;  // cycles without any handshake

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_word             out_word;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  cfg_ready;
    int                    fail_count;
    int                    pending;

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_tgl      = 1'b0;
    logic hold_seen     = 1'b0;
    int   hold_left     = 0;
    int   quiet         = 0;

    wire in_fire  = in_valid && !in_stall;
    wire out_fire = out_valid && !out_stall;
    wire cfg_fire = cfg_valid && cfg_ready;

    tagged_exchange_sort #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_word  (in_word),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_word (out_word),
        .i_out_stall(out_stall),
        .i_cfg_valid(cfg_valid),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .o_cfg_ready(cfg_ready)
    );

    tagged_exchange_sort_chk #(
        .DEPTH(DEPTH)
    ) u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out_word  (out_word),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_cfg_ready (cfg_ready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, except when a hold-off is requested. A toggle
    // of hold_tgl starts one long hold, counted here, so the block backs up
    // and stalls its input while the sender keeps offering words.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: too long without any accepted word means the block hung.
    always @(posedge clk) begin
        if (!rst_n || in_fire || out_fire || cfg_fire) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("tagged_exchange_sort_tb: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // One input word. Valid stays high into the next word when no idle
    // cycle is drawn, so it is never dropped and raised in one step.
    task automatic send_word(input logic signed [31:0] key, input logic [7:0] tag,
                             input logic last);
        t_in_word w;
        w.key  = key;
        w.tag  = tag;
        w.last = last;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    // Register writes back to back: a junk index first (must be ignored),
    // then both real registers. Upper data bits are noise.
    task automatic set_mode(input logic desc, input logic gap);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'($urandom_range(CFG_GAP_MODE + 1, (1 << CFG_IDX_W) - 1));
        cfg_data  <= CFG_DATA_W'($urandom_range(0, 255));
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_DESCENDING;
        cfg_data  <= {7'($urandom_range(0, 127)), desc};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_GAP_MODE;
        cfg_data  <= {7'($urandom_range(0, 127)), gap};
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every expected word, then let the block settle. Pending is
    // sampled on the falling edge, away from the checker's updates.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Keys: full-range noise, a narrow band that makes ties, and extremes.
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7fffffff;
                    1:       return 32'sh80000000;
                    2:       return 32'sh0;
                    default: return -32'sh1;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_word(pick_key(), 8'($urandom_range(0, 255)), i == n - 1);
    endtask

    initial begin : stim
        int n;
        int sent;
        int mix;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ascending, no gaps
        set_mode(1'b0, 1'b0);
        send_word(32'sh7fffffff, 8'hff, 1'b0);
        send_word(32'sh80000000, 8'h00, 1'b0);
        send_word(32'sh5, 8'h11, 1'b0);          // equal keys (exchange sort, not stable)
        send_word(32'sh5, 8'h22, 1'b0);
        send_word(-32'sh1, 8'h33, 1'b1);
        send_word(-32'sh100, 8'h44, 1'b1);      // set of one record
        for (int i = 0; i < DEPTH + 2; i++)     // two words past capacity, both dropped
            send_word(32'(DEPTH - i) <<< 8, 8'(i), i == DEPTH + 1);
        drain();

        // directed: descending, gap mode, saturation to both rails
        set_mode(1'b1, 1'b1);
        send_word(32'sh7fffffff, 8'h01, 1'b0);
        send_word(32'sh80000000, 8'h02, 1'b0);
        send_word(32'sh7fffffff, 8'h03, 1'b0);
        send_word(32'sh0, 8'h04, 1'b1);
        send_word(32'sh3039, 8'h05, 1'b1);      // first key of a set stays raw
        drain();

        // random phases: idling mix changes every two phases, and the
        // register setting walks all four combinations per mix pair
        for (int p = 0; p < PHASES; p++) begin
            mix = p / 2;
            set_mode(p[0], p[1] ^ p[2]);
            case (mix)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 65; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 65; end
                default: begin send_idle_pct = 25; stall_pct <= 25; end
            endcase
            if (p == 0)
                hold_tgl <= ~hold_tgl;
            sent = 0;
            while (sent < RANDOM_WORDS / PHASES) begin
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(DEPTH + 1, DEPTH + 4);
                else
                    n = $urandom_range(1, DEPTH);
                send_set(n);
                sent += n;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("tagged_exchange_sort_tb: PASS");
        else
            $display("tagged_exchange_sort_tb: FAIL");
        $finish;
    end

endmodule

// ===== tagged_exchange_sort.f =====
rtl/core/tes_pkg.sv
rtl/core/tes_ctrl.sv
rtl/core/tes_dp.sv
rtl/core/tagged_exchange_sort.sv
test/tagged_exchange_sort_chk.sv
test/tagged_exchange_sort_tb.sv
